// ----- src/point_store_radius_and_nearest_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the point store
// Shared property forms used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef POINT_STORE_RADIUS_AND_NEAREST_MACROS_SVH
`define POINT_STORE_RADIUS_AND_NEAREST_MACROS_SVH

// same-cycle implication, disabled during reset
`define PSRN_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("point store check failed");

// next-cycle implication, disabled during reset
`define PSRN_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("point store check failed");

`endif

// ----- src/psrn_pkg.sv -----
// ----------------------------------------------------------------------------
// psrn_pkg
// Types and fixed constants of the point store with radius and nearest search.
// ----------------------------------------------------------------------------
package psrn_pkg;

    localparam int COORD_IN_W = 16;
    localparam int INDEX_W    = 6;
    localparam int DIST_W     = 34;
    localparam int KIND_W     = 3;

    // cycles between the last memory read and the closing result
    localparam int DRAIN_CYCLES = 3;
    localparam int DRAIN_W      = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_EDGE    = 3'd0,
        KIND_NO_EDGE = 3'd1,
        KIND_FOUND   = 3'd2,
        KIND_EMPTY   = 3'd3,
        KIND_FULL    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;    // request accepted: capture point, write memory
        logic issue;   // read the entry at the scan pointer
        logic finish;  // emit the closing result
    } ctrl_cmd_t;

    typedef struct packed {
        logic skip;      // nothing to scan for this request
        logic ptr_last;  // scan pointer is on the last entry
    } dp_status_t;

endpackage

// ----- src/psrn_ctrl.sv -----
// ----------------------------------------------------------------------------
// psrn_ctrl
// Sequencer: accept a request, step the scan, wait out the pipeline, close.
// ----------------------------------------------------------------------------
module psrn_ctrl
    import psrn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output logic       busy,
    output ctrl_cmd_t  cmd
);

    state_t               state_reg;
    state_t               state_next;
    logic [DRAIN_W-1:0]   drain_reg;
    logic [DRAIN_W-1:0]   drain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.skip ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.ptr_last)
                begin
                    state_next = ST_DRAIN;
                    drain_next = DRAIN_W'(DRAIN_CYCLES - 1);
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    drain_next = drain_reg - DRAIN_W'(1);
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/psrn_datapath.sv -----
// ----------------------------------------------------------------------------
// psrn_datapath
// Point memory, squared-distance pipeline, edge and nearest tracking, outputs.
// ----------------------------------------------------------------------------
module psrn_datapath
    import psrn_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int COORD_WIDTH = 16,
    parameter int DIMENSIONS  = 3
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ctrl_cmd_t                    cmd,
    input  logic                         op,
    input  logic signed [COORD_IN_W-1:0] coord_x,
    input  logic signed [COORD_IN_W-1:0] coord_y,
    input  logic signed [COORD_IN_W-1:0] coord_z,
    input  logic                         cfg_we,
    input  logic [DIST_W-1:0]            cfg_data,
    output dp_status_t                   status,
    output logic                         result_valid,
    output logic [KIND_W-1:0]            kind,
    output logic [INDEX_W-1:0]           new_index,
    output logic [INDEX_W-1:0]           other_index,
    output logic [DIST_W-1:0]            distance_squared,
    output logic                         last
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int SQ_W   = 2 * COORD_WIDTH;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;
    localparam int WORD_W = DIMENSIONS * COORD_WIDTH;

    // point memory, no reset: entries are read only below the fill count
    logic [WORD_W-1:0]             mem [CAPACITY];
    logic [WORD_W-1:0]             rd_data_reg;

    logic [DIST_W-1:0]             radius_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              limit_reg;
    logic [IDX_W-1:0]              ptr_reg;
    logic                          op_reg;
    logic                          full_reg;
    logic [IDX_W-1:0]              id_reg;
    logic [WORD_W-1:0]             pt_reg;

    logic                          v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]              idx1_reg, idx2_reg, idx3_reg;
    logic [SQ_W-1:0]               sq2_reg [DIMENSIONS];
    logic [SUM_W-1:0]              sum3_reg;

    logic                          pend_valid_reg;
    logic [IDX_W-1:0]              pend_idx_reg;
    logic [SUM_W-1:0]              pend_d_reg;
    logic                          best_valid_reg;
    logic [IDX_W-1:0]              best_idx_reg;
    logic [SUM_W-1:0]              best_d_reg;

    logic                          out_valid_reg;
    kind_t                         kind_reg;
    logic [INDEX_W-1:0]            new_index_reg;
    logic [INDEX_W-1:0]            other_index_reg;
    logic [DIST_W-1:0]             dist_reg;
    logic                          last_reg;

    logic [WORD_W-1:0]             pt_in;
    logic                          is_full;
    logic                          mem_we;
    logic [SQ_W-1:0]               sq_next [DIMENSIONS];
    logic [SUM_W-1:0]              sum_next;
    logic                          edge_hit;
    logic                          best_hit;

    // low COORD_WIDTH bits of each coordinate, sign-extended first if wider
    always_comb
    begin
        logic signed [31:0] wide [3];
        wide[0] = 32'(coord_x);
        wide[1] = 32'(coord_y);
        wide[2] = 32'(coord_z);
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            pt_in[d*COORD_WIDTH +: COORD_WIDTH] = wide[d][COORD_WIDTH-1:0];
        end
    end

    assign is_full         = (count_reg == CNT_W'(CAPACITY));
    assign status.skip     = (count_reg == '0) || ((op == OP_INSERT) && is_full);
    assign status.ptr_last = ((CNT_W'(ptr_reg) + CNT_W'(1)) == limit_reg);
    assign mem_we          = cmd.load && (op == OP_INSERT) && !is_full;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= pt_in;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
    end

    always_comb
    begin
        logic signed [DIFF_W-1:0]   diff;
        logic signed [2*DIFF_W-1:0] prod;
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            diff = DIFF_W'($signed(pt_reg[d*COORD_WIDTH +: COORD_WIDTH]))
                 - DIFF_W'($signed(rd_data_reg[d*COORD_WIDTH +: COORD_WIDTH]));
            prod = diff * diff;
            sq_next[d] = prod[SQ_W-1:0];
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            sum_next = sum_next + SUM_W'(sq2_reg[d]);
        end
    end

    assign edge_hit = v3_reg && (op_reg == OP_INSERT)
                   && (CMP_W'(sum3_reg) < CMP_W'(radius_reg));
    assign best_hit = v3_reg && (op_reg == OP_QUERY)
                   && (!best_valid_reg || (sum3_reg < best_d_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg     <= '0;
            count_reg      <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            ptr_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_data;
            end
            if (mem_we)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.load)
            begin
                ptr_reg        <= '0;
                pend_valid_reg <= 1'b0;
                best_valid_reg <= 1'b0;
            end
            else if (cmd.issue)
            begin
                ptr_reg <= ptr_reg + IDX_W'(1);
            end
            if (edge_hit)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (best_hit)
            begin
                best_valid_reg <= 1'b1;
            end
            out_valid_reg <= cmd.finish || (edge_hit && pend_valid_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            pt_reg    <= pt_in;
            full_reg  <= is_full;
            limit_reg <= count_reg;
            id_reg    <= count_reg[IDX_W-1:0];
        end
        idx1_reg <= ptr_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            sq2_reg[d] <= sq_next[d];
        end
        sum3_reg <= sum_next;
        if (edge_hit)
        begin
            pend_idx_reg <= idx3_reg;
            pend_d_reg   <= sum3_reg;
        end
        if (best_hit)
        begin
            best_idx_reg <= idx3_reg;
            best_d_reg   <= sum3_reg;
        end

        // a new edge releases the one held back, which is then known not to be last
        if (edge_hit && pend_valid_reg)
        begin
            kind_reg        <= KIND_EDGE;
            new_index_reg   <= INDEX_W'(id_reg);
            other_index_reg <= INDEX_W'(pend_idx_reg);
            dist_reg        <= DIST_W'(pend_d_reg);
            last_reg        <= 1'b0;
        end
        else if (cmd.finish)
        begin
            last_reg <= 1'b1;
            if (op_reg == OP_INSERT)
            begin
                if (full_reg)
                begin
                    kind_reg        <= KIND_FULL;
                    new_index_reg   <= '0;
                    other_index_reg <= '0;
                    dist_reg        <= '0;
                end
                else if (pend_valid_reg)
                begin
                    kind_reg        <= KIND_EDGE;
                    new_index_reg   <= INDEX_W'(id_reg);
                    other_index_reg <= INDEX_W'(pend_idx_reg);
                    dist_reg        <= DIST_W'(pend_d_reg);
                end
                else
                begin
                    kind_reg        <= KIND_NO_EDGE;
                    new_index_reg   <= INDEX_W'(id_reg);
                    other_index_reg <= '0;
                    dist_reg        <= '0;
                end
            end
            else
            begin
                new_index_reg <= '0;
                if (limit_reg == '0)
                begin
                    kind_reg        <= KIND_EMPTY;
                    other_index_reg <= '0;
                    dist_reg        <= '0;
                end
                else
                begin
                    kind_reg        <= KIND_FOUND;
                    other_index_reg <= INDEX_W'(best_idx_reg);
                    dist_reg        <= DIST_W'(best_d_reg);
                end
            end
        end
    end

    assign result_valid     = out_valid_reg;
    assign kind             = kind_reg;
    assign new_index        = new_index_reg;
    assign other_index      = other_index_reg;
    assign distance_squared = dist_reg;
    assign last             = last_reg;

endmodule

// ----- src/point_store_radius_and_nearest.sv -----
// ----------------------------------------------------------------------------
// point_store_radius_and_nearest
// Point store with radius linking on insert and nearest-point query.
// ----------------------------------------------------------------------------
// Requests: start with op and coord_x/y/z is taken when busy is low. op 0
// inserts the point at the next index and reports every earlier point closer
// than the radius as an edge, in index order; op 1 returns the nearest point.
// Results: result_valid marks each result for exactly one cycle; last marks
// the final result of a request. The receiver cannot stall the block.
// Configuration: cfg_data is written to the squared radius when cfg_valid and
// cfg_ready are high; cfg_ready is high while the block is idle.
// Timing: with N stored points a request scans them at one memory read per
// cycle through the registered distance pipeline (read, squares, sum). The
// final result appears in the same cycle as busy drops, so a new request
// can be taken as soon as the final result is shown. Edges other than the
// last appear while busy is still high. A full-store insert, an empty-store query
// and the first insert go straight from idle to closing, with no scan.
// Reset: the point count and radius clear at once; no clearing pass runs.
// ----------------------------------------------------------------------------
`include "point_store_radius_and_nearest_macros.svh"

module point_store_radius_and_nearest
    import psrn_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int COORD_WIDTH = 16,
    parameter int DIMENSIONS  = 3
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         op,
    input  logic signed [COORD_IN_W-1:0] coord_x,
    input  logic signed [COORD_IN_W-1:0] coord_y,
    input  logic signed [COORD_IN_W-1:0] coord_z,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [DIST_W-1:0]            cfg_data,
    output logic                         result_valid,
    output logic [KIND_W-1:0]            kind,
    output logic [INDEX_W-1:0]           new_index,
    output logic [INDEX_W-1:0]           other_index,
    output logic [DIST_W-1:0]            distance_squared,
    output logic                         last
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = !busy;

    psrn_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    psrn_datapath #(
        .CAPACITY    (CAPACITY),
        .COORD_WIDTH (COORD_WIDTH),
        .DIMENSIONS  (DIMENSIONS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .op               (op),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .coord_z          (coord_z),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .status           (status),
        .result_valid     (result_valid),
        .kind             (kind),
        .new_index        (new_index),
        .other_index      (other_index),
        .distance_squared (distance_squared),
        .last             (last)
    );

    `PSRN_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `PSRN_ASSERT_NOW(a_last_idle, clk, rst_n, result_valid && last, !busy)
    `PSRN_ASSERT_NOW(a_mid_busy, clk, rst_n, result_valid && !last, busy && (kind == KIND_EDGE))
    `PSRN_ASSERT_NOW(a_scan_busy, clk, rst_n, cmd.issue || cmd.finish, busy && !cmd.load)

endmodule
